>>> design/pdcp_pkg.sv
// Shared types, codes and constants for the PCM dither, clip and pack core.
package pdcp_pkg;

	// Sample format: signed Q4.28
	localparam int SAMPLE_W  = 32;
	localparam int FRAC_BITS = 28;
	// Quantized value width before packing: sign plus fraction bits
	localparam int QVAL_W    = FRAC_BITS + 1;
	localparam int MAX_EFF   = 24;
	localparam logic [7:0] OFFSET8 = 8'h80;

	// Channel word and frame widths
	localparam int WORD_W    = 32;
	localparam int PACKED_W  = 64;
	localparam int COUNT_W   = 4;
	localparam int CLIPCNT_W = 32;
	localparam int PEAK_W    = 31;

	// Stream payload widths
	localparam int S_TDATA_W = 2 * SAMPLE_W;
	localparam int M_FIELD_W = PACKED_W + COUNT_W + CLIPCNT_W + PEAK_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO     = 1'd1;

	// Resolution codes
	typedef logic [1:0] res_code_t;
	localparam res_code_t RES_8  = 2'd0;
	localparam res_code_t RES_16 = 2'd1;
	localparam res_code_t RES_24 = 2'd2;
	localparam res_code_t RES_32 = 2'd3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Per-channel clip status handed to the shared counter and peak logic
	typedef struct packed {
		logic              clipped;
		logic              peak_ok;
		logic [PEAK_W-1:0] over;
	} quant_stat_t;

endpackage

>>> design/pdcp_quant.sv
// One channel: error feedback add, saturate, clip, quantize and word format.
module pdcp_quant (
	input  pdcp_pkg::sample_t         sample,
	input  pdcp_pkg::sample_t         err_old,
	input  pdcp_pkg::res_code_t       res_code,
	output pdcp_pkg::sample_t         err_new,
	output pdcp_pkg::quant_stat_t     stat,
	output logic [pdcp_pkg::WORD_W-1:0] word
);
	import pdcp_pkg::*;

	logic signed [SAMPLE_W:0] sum_w;
	sample_t                  sum;
	logic                     clip_hi;
	logic                     clip_lo;
	logic [QVAL_W-1:0]        q_clip;
	logic [QVAL_W-1:0]        q_mask;
	logic [QVAL_W-1:0]        q_val;
	logic [SAMPLE_W-1:0]      over_w;
	sample_t                  half_lsb;

	// Add the stored error and saturate to 32 bits
	assign sum_w = {sample[SAMPLE_W-1], sample} + {err_old[SAMPLE_W-1], err_old};
	always_comb begin
		if (sum_w[SAMPLE_W] != sum_w[SAMPLE_W-1]) begin
			sum = sum_w[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			sum = sum_w[SAMPLE_W-1:0];
		end
	end

	// Clip to [-1, 1)
	assign clip_hi = !sum[SAMPLE_W-1] && (|sum[SAMPLE_W-2:FRAC_BITS]);
	assign clip_lo = sum[SAMPLE_W-1] && !(&sum[SAMPLE_W-2:FRAC_BITS]);

	always_comb begin
		priority if (clip_hi) begin
			q_clip = {1'b0, {FRAC_BITS{1'b1}}};
			over_w = sum - {{(SAMPLE_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
		end else if (clip_lo) begin
			q_clip = {1'b1, {FRAC_BITS{1'b0}}};
			over_w = {{(SAMPLE_W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}} - sum;
		end else begin
			q_clip = sum[QVAL_W-1:0];
			over_w = '0;
		end
	end

	// Low-bit mask and peak-update error bound (2**(width-1)) for the selected width
	always_comb begin
		unique case (res_code)
			RES_8: begin
				q_mask   = QVAL_W'(29'h01F_FFFF);
				half_lsb = SAMPLE_W'(32'sd128);
			end
			RES_16: begin
				q_mask   = QVAL_W'(29'h000_1FFF);
				half_lsb = SAMPLE_W'(32'sd32768);
			end
			default: begin
				q_mask   = QVAL_W'(29'h000_001F);
				half_lsb = SAMPLE_W'(32'sd8388608);
			end
		endcase
	end

	assign q_val   = q_clip & ~q_mask;
	assign err_new = sum - {{(SAMPLE_W-QVAL_W){q_val[QVAL_W-1]}}, q_val};

	assign stat.clipped = clip_hi || clip_lo;
	assign stat.peak_ok = (err_old < half_lsb) && (err_old > -half_lsb);
	assign stat.over    = over_w[PEAK_W-1:0];

	// Format the channel word, low byte first
	always_comb begin
		unique case (res_code)
			RES_8:   word = {24'd0, q_val[QVAL_W-1:QVAL_W-8] ^ OFFSET8};
			RES_16:  word = {16'd0, q_val[QVAL_W-1:QVAL_W-16]};
			RES_24:  word = {8'd0, q_val[QVAL_W-1:QVAL_W-MAX_EFF]};
			default: word = {q_val[QVAL_W-1:QVAL_W-MAX_EFF], 8'd0};
		endcase
	end

endmodule

>>> design/pdcp_pack.sv
// Frame packer: joins left and right channel words and counts valid bytes.
module pdcp_pack (
	input  logic [pdcp_pkg::WORD_W-1:0]   word_l,
	input  logic [pdcp_pkg::WORD_W-1:0]   word_r,
	input  pdcp_pkg::res_code_t           res_code,
	input  logic                          stereo,
	output logic [pdcp_pkg::PACKED_W-1:0] packed_data,
	output logic [pdcp_pkg::COUNT_W-1:0]  byte_count
);
	import pdcp_pkg::*;

	logic [PACKED_W-1:0] right_pos;
	logic [2:0]          nbytes;

	// Place the right word just above the left word's bytes
	always_comb begin
		unique case (res_code)
			RES_8:   right_pos = {24'd0, word_r, 8'd0};
			RES_16:  right_pos = {16'd0, word_r, 16'd0};
			RES_24:  right_pos = {8'd0, word_r, 24'd0};
			default: right_pos = {word_r, 32'd0};
		endcase
	end

	assign packed_data = {{(PACKED_W-WORD_W){1'b0}}, word_l} | (stereo ? right_pos : '0);

	assign nbytes     = {1'b0, res_code} + 3'd1;
	assign byte_count = stereo ? {nbytes, 1'b0} : {1'b0, nbytes};

endmodule

>>> design/pcm_dither_clip_pack_core.sv
// Top level: input register, per-channel quantizers, packer and result register.
// Path: an accepted input beat passes the input register, then the result register,
// before its result beat shows on m_tvalid.
// Throughput: 1 frame per cycle unless m_tready stalls; the error, clip counter
// and peak load together with the result register, so the next frame sees them at once.
// Reset: arst_n clears valids, errors, clip counter and peak; resolution_code
// resets to 16-bit and stereo_mode to stereo.
module pcm_dither_clip_pack_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_wr_en,
	input  logic [pdcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdcp_pkg::CFG_DAT_W-1:0] cfg_data,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pdcp_pkg::S_TDATA_W-1:0] s_tdata,  // left_sample[31:0], right_sample[63:32]
	input  logic                           s_tlast,  // block_end
	// Output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// packed_data[63:0], byte_count[67:64], clip_total[99:68], clip_peak[130:100], zero pad
	output logic [pdcp_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast   // block_end_out
);
	import pdcp_pkg::*;

	// Configuration and channel state
	res_code_t              res_q;
	logic                   stereo_q;
	sample_t                left_err_q;
	sample_t                right_err_q;
	logic [CLIPCNT_W-1:0]   clip_cnt_q;
	logic [PEAK_W-1:0]      peak_q;

	// Input stage
	logic                   vld_s1;
	sample_t                left_s1;
	sample_t                right_s1;
	logic                   last_s1;

	// Result stage
	logic                   vld_s2;
	logic [PACKED_W-1:0]    packed_s2;
	logic [COUNT_W-1:0]     count_s2;
	logic [CLIPCNT_W-1:0]   clip_cnt_s2;
	logic [PEAK_W-1:0]      peak_s2;
	logic                   last_s2;

	logic                   advance;
	logic                   fire;
	sample_t                left_err_nx;
	sample_t                right_err_nx;
	quant_stat_t            stat_l;
	quant_stat_t            stat_r;
	logic [WORD_W-1:0]      word_l;
	logic [WORD_W-1:0]      word_r;
	logic [PACKED_W-1:0]    packed_nx;
	logic [COUNT_W-1:0]     count_nx;
	logic [PEAK_W-1:0]      peak_mid;
	logic [PEAK_W-1:0]      peak_nx;
	logic [1:0]             clip_inc;
	logic [CLIPCNT_W:0]     clip_sum;
	logic [CLIPCNT_W-1:0]   clip_cnt_nx;

	// Handshake: the result register frees the input stage
	assign advance  = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign fire     = vld_s1 && advance;

	pdcp_quant u_quant_l (
		.sample   (left_s1),
		.err_old  (left_err_q),
		.res_code (res_q),
		.err_new  (left_err_nx),
		.stat     (stat_l),
		.word     (word_l)
	);

	pdcp_quant u_quant_r (
		.sample   (right_s1),
		.err_old  (right_err_q),
		.res_code (res_q),
		.err_new  (right_err_nx),
		.stat     (stat_r),
		.word     (word_r)
	);

	pdcp_pack u_pack (
		.word_l      (word_l),
		.word_r      (word_r),
		.res_code    (res_q),
		.stereo      (stereo_q),
		.packed_data (packed_nx),
		.byte_count  (count_nx)
	);

	// Raise the peak: left channel first, right against the updated value
	always_comb begin
		peak_mid = peak_q;
		if (stat_l.clipped && stat_l.peak_ok && (stat_l.over > peak_q)) begin
			peak_mid = stat_l.over;
		end
		peak_nx = peak_mid;
		if (stereo_q && stat_r.clipped && stat_r.peak_ok && (stat_r.over > peak_mid)) begin
			peak_nx = stat_r.over;
		end
	end

	// Bump the clip counter, hold at full scale
	assign clip_inc    = {1'b0, stat_l.clipped} + {1'b0, stereo_q && stat_r.clipped};
	assign clip_sum    = {1'b0, clip_cnt_q} + {{(CLIPCNT_W-1){1'b0}}, clip_inc};
	assign clip_cnt_nx = clip_sum[CLIPCNT_W] ? '1 : clip_sum[CLIPCNT_W-1:0];

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q       <= RES_16;
			stereo_q    <= 1'b1;
			left_err_q  <= '0;
			right_err_q <= '0;
			clip_cnt_q  <= '0;
			peak_q      <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_RESOLUTION: res_q    <= cfg_data;
					REG_STEREO:     stereo_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (advance) begin
				vld_s2 <= vld_s1;
			end
			if (fire) begin
				left_err_q <= left_err_nx;
				if (stereo_q) begin
					right_err_q <= right_err_nx;
				end
				clip_cnt_q <= clip_cnt_nx;
				peak_q     <= peak_nx;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			left_s1  <= s_tdata[SAMPLE_W-1:0];
			right_s1 <= s_tdata[S_TDATA_W-1:SAMPLE_W];
			last_s1  <= s_tlast;
		end
		if (fire) begin
			packed_s2   <= packed_nx;
			count_s2    <= count_nx;
			clip_cnt_s2 <= clip_cnt_nx;
			peak_s2     <= peak_nx;
			last_s2     <= last_s1;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {{(M_TDATA_W-M_FIELD_W){1'b0}}, peak_s2, clip_cnt_s2, count_s2, packed_s2};

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the PCM dither, clip and pack core.
module testbench;
	import pdcp_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 12;
	localparam int QUIET_LIMIT  = 5000;
	localparam int LONG_HOLD    = 250;
	localparam int HOLD_AT      = 400;
	localparam int PHASE_FRAMES = 110;

	localparam longint FULL_SCALE = 64'sd268435456;
	localparam longint SUM_MAX    = 64'sd2147483647;
	localparam longint SUM_MIN    = -64'sd2147483648;

	typedef struct {
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} frame_t;

	typedef struct {
		logic [63:0] pcm_bytes;
		logic [3:0]  nbytes;
		logic [31:0] clips;
		logic [30:0] peak;
		logic        last;
	} pcm_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	pcm_dither_clip_pack_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// Quantizer state and register copies
	logic signed [31:0] err_l;
	logic signed [31:0] err_r;
	logic [31:0]        clip_cnt;
	logic signed [31:0] peak_val;
	res_code_t          cur_res;
	logic               cur_stereo;

	frame_t      frames_to_send[$];
	pcm_result_t words_due[$];

	bit idle_on = 1'b1;
	bit in_taken = 1'b0;
	bit hold_done = 1'b0;
	int send_gap = 0;
	int hold_left = 0;
	int frames_in = 0;
	int mismatches = 0;
	int quiet = 0;

	pcm_result_t want;
	pcm_result_t got;

	// Add stored error, saturate, clip, quantize and format one channel word
	task automatic quantize_chan(input logic signed [31:0] smp, inout logic signed [31:0] err,
			input res_code_t res, output logic [31:0] word);
		int     bits;
		int     shift;
		longint mask;
		longint old_e;
		longint abs_e;
		longint half;
		longint sum;
		longint q;
		longint over;
		longint scaled;
		bits  = (res == RES_8) ? 8 : (res == RES_16) ? 16 : 24;
		shift = 29 - bits;
		mask  = (longint'(1) << shift) - 1;
		old_e = err;
		abs_e = (old_e < 0) ? -old_e : old_e;
		half  = FULL_SCALE >>> shift;
		sum   = longint'(smp) + old_e;
		if (sum > SUM_MAX)
			sum = SUM_MAX;
		if (sum < SUM_MIN)
			sum = SUM_MIN;
		q = sum;
		if (sum >= FULL_SCALE || sum < -FULL_SCALE) begin
			if (sum >= FULL_SCALE) begin
				q    = FULL_SCALE - 1;
				over = sum - q;
			end else begin
				q    = -FULL_SCALE;
				over = q - sum;
			end
			if (clip_cnt != 32'hFFFF_FFFF)
				clip_cnt = clip_cnt + 1;
			if (over > longint'(peak_val) && abs_e < half)
				peak_val = over[31:0];
		end
		q      = q - (q & mask);
		err    = 32'(sum - q);
		scaled = q >>> shift;
		case (res)
			RES_8:   word = 32'((scaled + longint'(OFFSET8)) & 64'hFF);
			RES_16:  word = 32'(scaled & 64'hFFFF);
			RES_24:  word = 32'(scaled & 64'hFF_FFFF);
			default: word = 32'(scaled << 8);
		endcase
	endtask

	// Work out the packed result of one frame and advance the state
	task automatic dither_frame(input logic [31:0] left, input logic [31:0] right,
			input logic last, output pcm_result_t res_out);
		logic [31:0] wl;
		logic [31:0] wr;
		int          nb;
		nb = int'(cur_res) + 1;
		quantize_chan(left, err_l, cur_res, wl);
		res_out.pcm_bytes = {32'd0, wl};
		res_out.nbytes    = 4'(nb);
		if (cur_stereo) begin
			quantize_chan(right, err_r, cur_res, wr);
			res_out.pcm_bytes = res_out.pcm_bytes | ({32'd0, wr} << (8 * nb));
			res_out.nbytes    = 4'(2 * nb);
		end
		res_out.clips = clip_cnt;
		res_out.peak  = peak_val[30:0];
		res_out.last  = last;
	endtask

	// Sender: hold a beat until taken, then offer the next or idle a burst
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (frames_to_send.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 13);
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= {frames_to_send[0].right, frames_to_send[0].left};
				s_tlast  <= frames_to_send[0].last;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once traffic is flowing
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (!hold_done && frames_in >= HOLD_AT) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				m_tready  <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_left <= $urandom_range(0, 13);
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: check result beats, predict on accepted input beats
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.pcm_bytes = m_tdata[63:0];
				got.nbytes    = m_tdata[67:64];
				got.clips     = m_tdata[99:68];
				got.peak      = m_tdata[130:100];
				got.last      = m_tlast;
				if (words_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: bytes=%h n=%0d clips=%0d peak=%h last=%b",
							got.pcm_bytes, got.nbytes, got.clips, got.peak, got.last);
					mismatches++;
				end else begin
					want = words_due.pop_front();
					if (got.pcm_bytes !== want.pcm_bytes || got.nbytes !== want.nbytes ||
							got.clips !== want.clips || got.peak !== want.peak ||
							got.last !== want.last) begin
						if (mismatches < 10) begin
							$display("mismatch want: bytes=%h n=%0d clips=%0d peak=%h last=%b",
								want.pcm_bytes, want.nbytes, want.clips, want.peak, want.last);
							$display("         got:  bytes=%h n=%0d clips=%0d peak=%h last=%b",
								got.pcm_bytes, got.nbytes, got.clips, got.peak, got.last);
						end
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				frames_to_send.delete(0);
				dither_frame(s_tdata[31:0], s_tdata[63:32], s_tlast, want);
				words_due.push_back(want);
				frames_in++;
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("** pcm_dither_clip_pack_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic queue_frame(input logic [31:0] left, input logic [31:0] right,
			input logic last);
		frame_t f;
		f.left  = left;
		f.right = right;
		f.last  = last;
		frames_to_send.push_back(f);
	endtask

	// Mix of full-range, in-range, near-full-scale, tiny and extreme samples
	function automatic logic [31:0] pick_sample();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0:       v = $urandom;
			1:       v = 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
			2:       v = 32'h1000_0000 + 32'($urandom_range(0, 32'hFFFF)) - 32'h8000;
			3:       v = 32'hF000_0000 + 32'($urandom_range(0, 32'hFFFF)) - 32'h8000;
			4:       v = 32'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000);
			default: v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
		return v;
	endfunction

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_RESOLUTION)
			cur_res = res_code_t'(val);
		else
			cur_stereo = val[0];
	endtask

	task automatic drain();
		while (frames_to_send.size() != 0 || words_due.size() != 0)
			@(posedge clk);
	endtask

	res_code_t phase_res[8]    = '{RES_8, RES_8, RES_32, RES_32, RES_24, RES_16, RES_24, RES_16};
	bit        phase_stereo[8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	initial begin
		err_l      = '0;
		err_r      = '0;
		clip_cnt   = '0;
		peak_val   = '0;
		cur_res    = RES_16;
		cur_stereo = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames at reset settings: zero, edges of full scale,
		// extremes with sum saturation, and small-error peak updates
		queue_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_frame(32'h0FFF_FFFF, 32'hF000_0000, 1'b1);
		queue_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_frame(32'h1000_0100, 32'hEFFF_FF00, 1'b0);
		queue_frame(32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_frame(32'h1000_4000, 32'hEFFF_0000, 1'b0);
		queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		queue_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_frame(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
		queue_frame(32'h0000_1FFF, 32'hFFFF_E001, 1'b0);
		queue_frame(32'h0555_5555, 32'hFAAA_AAAB, 1'b0);
		queue_frame(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		queue_frame(32'h1000_0000, 32'hEFFF_FFFF, 1'b0);
		queue_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_frame(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
		queue_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
		drain();

		// Random frames across every register setting; last phase runs without idling
		for (int p = 0; p < 8; p++) begin
			set_reg(REG_RESOLUTION, CFG_DAT_W'(phase_res[p]));
			set_reg(REG_STEREO, CFG_DAT_W'(phase_stereo[p]));
			if (p == 7)
				idle_on = 1'b0;
			for (int i = 0; i < PHASE_FRAMES; i++)
				queue_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("** pcm_dither_clip_pack_core: PASSED **");
		end else begin
			$display("** pcm_dither_clip_pack_core: FAILED **");
		end
		$finish;
	end

endmodule
